[src/speht_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speht_pkg
// Shared types and codes for the stroke point eraser hit test.
// ---------------------------------------------------------------------------
package speht_pkg;

  typedef logic [1:0]          mode_t;
  typedef logic [1:0]          status_t;
  typedef logic signed [15:0]  coord_t;
  typedef logic signed [17:0]  box_t;
  typedef logic [31:0]         point_t;   // y in 31..16, x in 15..0
  typedef logic [7:0]          radius_t;

  localparam int R2_W = 24;
  typedef logic [R2_W-1:0]     r2_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_QUERY  = 2'd2;

  localparam status_t ST_ACCEPT = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_QUERY  = 2'd2;

  localparam radius_t RADIUS_RESET = 8'd10;

  typedef struct packed {
    logic busy;
    logic valid;
    logic hit;
  } dist_stat_t;

endpackage

[src/stroke_point_eraser_hit_test_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stroke_point_eraser_hit_test_core
// Stroke point store with bounding box and eraser radius hit test.
//
//   channel  direction  handshake            word
//   input    in         in_valid / in_stall  mode, x, y
//   output   out        out_valid/out_stall  status, group_base, hit_mask, last
//   config   in         cfg_write            cfg_data (eraser radius)
//
// Clear, append, outside query: word set up in S_PROC, registered out in S_EMIT,
// then back to S_IDLE for the next accept.
// Inside query, per group of MASK_WIDTH points: S_QRUN does one memory read a
// cycle, S_QDRAIN waits for the distance pipeline to empty, S_EMIT sends a word.
// Reset clears count and box, sets the radius to 10; point memory not cleared.
// A stalled output holds the block; input is taken while the last word waits.
// ---------------------------------------------------------------------------
module stroke_point_eraser_hit_test_core #(
  parameter int MAX_POINTS = 1024,
  parameter int MASK_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  speht_pkg::mode_t                 mode,
  input  speht_pkg::coord_t                x,
  input  speht_pkg::coord_t                y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output speht_pkg::status_t               status,
  output logic [$clog2(MAX_POINTS)-1:0]    group_base,
  output logic [MASK_WIDTH-1:0]            hit_mask,
  output logic                             last,
  input  logic                             cfg_write,
  input  speht_pkg::radius_t               cfg_data
);
  import speht_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = $clog2(MASK_WIDTH);

  typedef enum logic [2:0] {S_IDLE, S_PROC, S_QRUN, S_QDRAIN, S_EMIT} state_t;

  state_t          state;
  mode_t           it_mode;
  coord_t          q_x;
  coord_t          q_y;
  radius_t         radius;
  r2_t             r2;
  logic [CW-1:0]   count;
  box_t            box_left;
  box_t            box_right;
  box_t            box_top;
  box_t            box_bottom;
  logic [CW-1:0]   addr;
  logic [LW-1:0]   j;
  logic [LW-1:0]   lane;
  logic [AW-1:0]   grp_base;
  logic            grp_last;
  logic [MASK_WIDTH-1:0] mask;
  status_t         res_status;
  logic [AW-1:0]   res_base;
  logic [MASK_WIDTH-1:0] res_mask;
  logic            res_last;

  logic            out_free;
  logic            full;
  logic            outside;
  logic [CW-1:0]   addr_inc;
  logic            wr_en;
  logic            rd_en;
  point_t          rd_data;
  logic            rd_valid;
  dist_stat_t      dstat;
  box_t            x_ext;
  box_t            y_ext;
  box_t            margin;
  box_t            x_lo;
  box_t            x_hi;
  box_t            y_lo;
  box_t            y_hi;
  logic [15:0]     rsq;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CW'(MAX_POINTS));
  assign addr_inc = addr + CW'(1);
  assign wr_en    = (state == S_PROC) && (it_mode == MODE_APPEND) && !full;
  assign rd_en    = (state == S_QRUN);
  assign rsq      = 16'(cfg_data) * 16'(cfg_data);

  assign x_ext  = {{2{q_x[15]}}, q_x};
  assign y_ext  = {{2{q_y[15]}}, q_y};
  assign margin = {6'b0, radius, 4'b0};
  assign x_lo   = x_ext - margin;
  assign x_hi   = x_ext + margin;
  assign y_lo   = y_ext - margin;
  assign y_hi   = y_ext + margin;
  assign outside = (x_ext < box_left) || (x_ext > box_right) ||
                   (y_ext < box_top) || (y_ext > box_bottom);

  speht_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (count[AW-1:0]),
    .wr_data  ({q_y, q_x}),
    .rd_en    (rd_en),
    .rd_addr  (addr[AW-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  speht_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (rd_valid),
    .pt       (rd_data),
    .qx       (q_x),
    .qy       (q_y),
    .r2       (r2),
    .stat     (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count      <= '0;
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
      radius     <= RADIUS_RESET;
      r2         <= {16'(RADIUS_RESET) * 16'(RADIUS_RESET), 8'b0};
    end else begin
      if (cfg_write && (cfg_data != '0)) begin
        radius <= cfg_data;
        r2     <= {rsq, 8'b0};   // (r*16)^2
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (dstat.valid) begin
        mask[lane] <= dstat.hit;
        lane       <= lane + LW'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_mode <= mode;
            q_x     <= x;
            q_y     <= y;
            state   <= S_PROC;
          end
        end
        S_PROC: begin
          res_base <= '0;
          res_mask <= '0;
          res_last <= 1'b1;
          case (it_mode)
            MODE_CLEAR: begin
              count      <= '0;
              box_left   <= '0;
              box_right  <= '0;
              box_top    <= '0;
              box_bottom <= '0;
              res_status <= ST_ACCEPT;
              state      <= S_EMIT;
            end
            MODE_APPEND: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                if ((count == '0) || (x_lo < box_left))   box_left   <= x_lo;
                if ((count == '0) || (x_hi > box_right))  box_right  <= x_hi;
                if ((count == '0) || (y_lo < box_top))    box_top    <= y_lo;
                if ((count == '0) || (y_hi > box_bottom)) box_bottom <= y_hi;
                count      <= count + CW'(1);
                res_status <= ST_ACCEPT;
                res_base   <= count[AW-1:0];
              end
              state <= S_EMIT;
            end
            MODE_QUERY: begin
              res_status <= ST_QUERY;
              if ((count == '0) || outside) begin
                state <= S_EMIT;
              end else begin
                addr     <= '0;
                j        <= '0;
                lane     <= '0;
                mask     <= '0;
                grp_base <= '0;
                state    <= S_QRUN;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_QRUN: begin
          addr <= addr_inc;
          j    <= j + LW'(1);
          if ((j == LW'(MASK_WIDTH - 1)) || (addr_inc == count)) begin
            grp_last <= (addr_inc == count);
            state    <= S_QDRAIN;
          end
        end
        S_QDRAIN: begin
          if (!dstat.busy) begin
            res_status <= ST_QUERY;
            res_base   <= grp_base;
            res_mask   <= mask;
            res_last   <= grp_last;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            group_base <= res_base;
            hit_mask   <= res_mask;
            last       <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              grp_base <= addr[AW-1:0];
              j        <= '0;
              lane     <= '0;
              mask     <= '0;
              state    <= S_QRUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/speht_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speht_store
// Point memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module speht_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  speht_pkg::point_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output speht_pkg::point_t rd_data,
  output logic              rd_valid
);
  import speht_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

[src/speht_dist.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speht_dist
// Squared distance pipeline: difference, square, sum and compare.
// ---------------------------------------------------------------------------
module speht_dist (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pt_valid,
  input  speht_pkg::point_t     pt,
  input  speht_pkg::coord_t     qx,
  input  speht_pkg::coord_t     qy,
  input  speht_pkg::r2_t        r2,
  output speht_pkg::dist_stat_t stat
);
  import speht_pkg::*;

  logic               v2;
  logic               v3;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [32:0]        sx;
  logic [32:0]        sy;
  logic signed [33:0] px2;
  logic signed [33:0] py2;
  logic [33:0]        d2;

  assign px2 = 34'(dx) * 34'(dx);
  assign py2 = 34'(dy) * 34'(dy);
  assign d2  = {1'b0, sx} + {1'b0, sy};

  always_ff @(posedge clk) begin
    dx <= {qx[15], qx} - {pt[15], pt[15:0]};
    dy <= {qy[15], qy} - {pt[31], pt[31:16]};
    sx <= px2[32:0];
    sy <= py2[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= pt_valid;
      v3 <= v2;
    end
  end

  always_comb begin
    stat.busy  = pt_valid | v2 | v3;
    stat.valid = v3;
    stat.hit   = d2 < {{(34-R2_W){1'b0}}, r2};
  end

endmodule
